// ===== design/plc_pkg.sv =====
// Shared types and constants for the piecewise linear adjustment block.
// No dependencies; every other design file but plc_ram imports this package.
package plc_pkg;

  localparam int MAX_POINTS_DEF = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PTS = 1'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic signed [31:0] ONE_Q16    = 32'sh0001_0000;
  localparam logic signed [31:0] FACTOR_MAX = 32'sh7FFF_FFFF;

  // quotient bits resolved by the divider; larger quotients saturate
  localparam int DIV_QBITS  = 36;
  localparam int DIV_BPS    = 3;
  localparam int DIV_STAGES = DIV_QBITS / DIV_BPS;
  localparam logic [DIV_QBITS-1:0] Q_SAT_LIMIT = 36'h4_0000_0000;

  typedef struct packed {
    logic               kind;
    logic [2:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] sample_value;
    logic               sample_valid;
  } plc_in_t;

  typedef struct packed {
    logic signed [31:0] factor;
    logic               used_default;
  } plc_out_t;

  // search result handed to the arithmetic stages
  typedef struct packed {
    logic               dflt;
    logic               pass;
    logic signed [31:0] v;
  } plc_seg_t;

  typedef struct packed {
    logic               dflt;
    logic               pass;
    logic signed [31:0] ly;
  } plc_tag_t;

  // divider stage contents: nq holds numerator bits, then the quotient
  typedef struct packed {
    plc_tag_t              tag;
    logic                  neg;
    logic                  ovf;
    logic [31:0]           rem;
    logic [DIV_QBITS-1:0]  nq;
    logic [31:0]           dx;
  } plc_div_t;

endpackage

// ===== design/piecewise_linear_adjustment.sv =====
// Top level of the piecewise linear adjustment block: config registers,
// pipeline advance, final combine and output register. Uses plc_pkg and all plc_* modules.
//
//   port group | dir | beat / meaning
//   in_*       | in  | plc_in_t: load one breakpoint or evaluate a sample
//   out_*      | out | plc_out_t: factor and default flag, one per evaluate
//   cfg_*      | in  | write enable, index, data; enabled and number of points
//
// One beat enters per cycle while in_stall is low; a result passes through, in order:
// three search/table stages, three arithmetic stages, DIV_STAGES divider stages
// and the output register. Load beats give no result.
// Reset is synchronous and clears valids and config; the table is undefined until loaded.
// A stall on out holds every stage only while a result waits, and in_stall rises only then.
module piecewise_linear_adjustment #(
  parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  plc_pkg::plc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output plc_pkg::plc_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import plc_pkg::*;

  logic               enabled_r;
  logic [CNT_W-1:0]   count_r;
  logic               adv;
  logic               in_acc;

  logic               seg_vld;
  plc_seg_t           seg;
  logic signed [31:0] lx;
  logic signed [31:0] ly;
  logic signed [31:0] rx;
  logic signed [31:0] ry;

  logic               dv_vld;
  plc_div_t           dv;
  logic               q_vld;
  plc_div_t           dq;

  logic               sat;
  logic [36:0]        ly_ext;
  logic [36:0]        q_ext;
  logic [36:0]        sum;
  plc_out_t           res;

  logic               out_vld_r;
  plc_out_t           out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED: enabled_r <= cfg_wdata[0];
        CFG_NUM_PTS: count_r   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  plc_search #(
    .MAX_POINTS (MAX_POINTS)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_acc      (in_acc),
    .in_item     (in_data),
    .cfg_enabled (enabled_r),
    .cfg_num_pts (count_r),
    .seg_vld     (seg_vld),
    .seg         (seg),
    .lx          (lx),
    .ly          (ly),
    .rx          (rx),
    .ry          (ry)
  );

  plc_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .seg_vld (seg_vld),
    .seg     (seg),
    .lx      (lx),
    .ly      (ly),
    .rx      (rx),
    .ry      (ry),
    .div_vld (dv_vld),
    .div_o   (dv)
  );

  plc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .d_vld (dv_vld),
    .d_in  (dv),
    .q_vld (q_vld),
    .q_out (dq)
  );

  always_comb begin
    sat    = dq.ovf || (dq.nq > Q_SAT_LIMIT);
    ly_ext = {{5{dq.tag.ly[31]}}, dq.tag.ly};
    q_ext  = {1'b0, dq.nq};
    sum    = dq.neg ? (ly_ext - q_ext) : (ly_ext + q_ext);
    res.used_default = 1'b0;
    if (dq.tag.dflt) begin
      res.factor       = ONE_Q16;
      res.used_default = 1'b1;
    end else if (dq.tag.pass) begin
      res.factor = dq.tag.ly;
    end else if (sat) begin
      res.factor = dq.neg ? '0 : FACTOR_MAX;
    end else if (sum[36]) begin
      res.factor = '0;
    end else if (|sum[35:31]) begin
      res.factor = FACTOR_MAX;
    end else begin
      res.factor = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid survived reset");

  a_default_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.used_default |-> out_data.factor == ONE_Q16)
    else $error("default flag without factor 1.0");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

endmodule

// ===== design/plc_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module plc_ram #(
  parameter int W  = 32,
  parameter int D  = 8,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_a_r;
  logic [W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== design/plc_search.sv =====
// Breakpoint table and segment search: stages 1 to 3 of the pipeline.
// Depends on plc_pkg and plc_ram.
module plc_search #(
  parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_acc,
  input  plc_pkg::plc_in_t            in_item,
  input  logic                        cfg_enabled,
  input  logic [plc_pkg::CNT_W-1:0]   cfg_num_pts,
  output logic                        seg_vld,
  output plc_pkg::plc_seg_t           seg,
  output logic signed [31:0]          lx,
  output logic signed [31:0]          ly,
  output logic signed [31:0]          rx,
  output logic signed [31:0]          ry
);
  import plc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  // stage 1
  logic                  s1_vld_r;
  plc_in_t               s1_r;
  logic signed [31:0]    bx_r [MAX_POINTS];
  logic                  load_ok;
  logic [MAX_POINTS-1:0] lt;
  logic                  gt0;

  // stage 2
  logic                  s2_vld_r;
  plc_in_t               s2_r;
  logic [MAX_POINTS-1:0] s2_lt_r;
  logic                  s2_gt0_r;
  logic [NW-1:0]         n;
  logic [AW-1:0]         nm1;
  logic [AW-1:0]         seg_i;
  logic [AW-1:0]         lo;
  logic [AW-1:0]         hi;
  logic                  dflt;
  logic                  first;
  logic                  last;
  logic                  ram_we;

  // stage 3
  logic                  s3_vld_r;
  plc_seg_t              s3_r;
  logic [63:0]           rd_a;
  logic [63:0]           rd_b;

  assign load_ok = (in_item.kind == KIND_LOAD) && (32'(in_item.point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_acc;
    end
  end

  // compare copy of x; written at accept so the next beat sees it
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_item;
    end
    if (in_acc && load_ok) begin
      bx_r[AW'(in_item.point_index)] <= in_item.point_x;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      lt[j] = s1_r.sample_value < bx_r[j];
    end
    gt0 = s1_r.sample_value > bx_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r     <= s1_r;
      s2_lt_r  <= lt;
      s2_gt0_r <= gt0;
    end
  end

  always_comb begin
    n = (32'(cfg_num_pts) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(cfg_num_pts);
    nm1   = AW'(n - NW'(1));
    dflt  = !cfg_enabled || !s2_r.sample_valid || (n == '0);
    first = !s2_gt0_r;
    last  = !s2_lt_r[nm1];
    // first segment whose right x lies above the sample, else the last one
    seg_i = AW'(n - NW'(2));
    for (int j = MAX_POINTS - 3; j >= 0; j--) begin
      if (s2_lt_r[j+1] && ((j + 2) < int'(n))) begin
        seg_i = AW'(j);
      end
    end
    if (first) begin
      lo = '0;
      hi = '0;
    end else if (last) begin
      lo = nm1;
      hi = nm1;
    end else begin
      lo = seg_i;
      hi = seg_i + AW'(1);
    end
  end

  // table write happens at this stage, the same place evaluates read it
  assign ram_we = adv && s2_vld_r && (s2_r.kind == KIND_LOAD)
                  && (32'(s2_r.point_index) < MAX_POINTS);

  plc_ram #(
    .W  (64),
    .D  (MAX_POINTS),
    .AW (AW)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(s2_r.point_index)),
    .wdata   ({s2_r.point_x, s2_r.point_y}),
    .re      (adv),
    .raddr_a (lo),
    .raddr_b (hi),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r && (s2_r.kind == KIND_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r.dflt <= dflt;
      s3_r.pass <= first || last;
      s3_r.v    <= s2_r.sample_value;
    end
  end

  assign seg_vld = s3_vld_r;
  assign seg     = s3_r;
  assign lx      = rd_a[63:32];
  assign ly      = rd_a[31:0];
  assign rx      = rd_b[63:32];
  assign ry      = rd_b[31:0];

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && adv && s1_vld_r |=> s2_vld_r)
    else $error("stage 1 beat lost on advance");

endmodule

// ===== design/plc_interp.sv =====
// Segment arithmetic: differences, magnitudes, product, overflow check.
// Stages 4 to 6. Depends on plc_pkg.
module plc_interp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                seg_vld,
  input  plc_pkg::plc_seg_t   seg,
  input  logic signed [31:0]  lx,
  input  logic signed [31:0]  ly,
  input  logic signed [31:0]  rx,
  input  logic signed [31:0]  ry,
  output logic                div_vld,
  output plc_pkg::plc_div_t   div_o
);
  import plc_pkg::*;

  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] t;
    t = d[32] ? (~d + 33'd1) : d;
    return t[31:0];
  endfunction

  logic        s4_vld_r;
  plc_tag_t    s4_tag_r;
  logic [32:0] s4_dv_r;
  logic [32:0] s4_dx_r;
  logic [32:0] s4_dy_r;

  logic        s5_vld_r;
  plc_tag_t    s5_tag_r;
  logic        s5_neg_r;
  logic [31:0] s5_mdv_r;
  logic [31:0] s5_mdy_r;
  logic [31:0] s5_mdx_r;

  logic        s6_vld_r;
  plc_tag_t    s6_tag_r;
  logic        s6_neg_r;
  logic [63:0] s6_prod_r;
  logic [31:0] s6_mdx_r;

  logic [63:0] prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= seg_vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  assign prod = s5_mdv_r * s5_mdy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tag_r.dflt <= seg.dflt;
      s4_tag_r.pass <= seg.pass || (lx == rx);
      s4_tag_r.ly   <= ly;
      s4_dv_r       <= {seg.v[31], seg.v} - {lx[31], lx};
      s4_dx_r       <= {rx[31], rx} - {lx[31], lx};
      s4_dy_r       <= {ry[31], ry} - {ly[31], ly};

      s5_tag_r <= s4_tag_r;
      s5_neg_r <= s4_dv_r[32] ^ s4_dy_r[32] ^ s4_dx_r[32];
      s5_mdv_r <= mag33(s4_dv_r);
      s5_mdy_r <= mag33(s4_dy_r);
      s5_mdx_r <= mag33(s4_dx_r);

      s6_tag_r  <= s5_tag_r;
      s6_neg_r  <= s5_neg_r;
      s6_prod_r <= prod;
      s6_mdx_r  <= s5_mdx_r;
    end
  end

  always_comb begin
    div_o.tag = s6_tag_r;
    div_o.neg = s6_neg_r;
    // quotient would not fit the divider's bits
    div_o.ovf = 32'(s6_prod_r[63:DIV_QBITS]) >= s6_mdx_r;
    div_o.rem = 32'(s6_prod_r[63:DIV_QBITS]);
    div_o.nq  = s6_prod_r[DIV_QBITS-1:0];
    div_o.dx  = s6_mdx_r;
  end

  assign div_vld = s6_vld_r;

endmodule

// ===== design/plc_div.sv =====
// Pipelined restoring divider, DIV_BPS quotient bits per stage.
// Depends on plc_pkg.
module plc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               d_vld,
  input  plc_pkg::plc_div_t  d_in,
  output logic               q_vld,
  output plc_pkg::plc_div_t  q_out
);
  import plc_pkg::*;

  function automatic plc_div_t div_steps(input plc_div_t d);
    plc_div_t    r;
    logic [32:0] t;
    r = d;
    for (int k = 0; k < DIV_BPS; k++) begin
      t    = {r.rem, r.nq[DIV_QBITS-1]};
      r.nq = {r.nq[DIV_QBITS-2:0], 1'b0};
      if (t >= {1'b0, r.dx}) begin
        t       = t - {1'b0, r.dx};
        r.nq[0] = 1'b1;
      end
      r.rem = t[31:0];
    end
    return r;
  endfunction

  logic [DIV_STAGES-1:0] vld_r;
  plc_div_t              st_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], d_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_steps(d_in);
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_r[k] <= div_steps(st_r[k-1]);
      end
    end
  end

  assign q_vld = vld_r[DIV_STAGES-1];
  assign q_out = st_r[DIV_STAGES-1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !adv |=> $stable(vld_r))
    else $error("divider pipeline moved while stalled");

endmodule

// ===== tb/piecewise_linear_adjustment_test.sv =====
// Self-checking bench for piecewise_linear_adjustment: a queue-fed driver with bursty valid,
// a stalling receiver, and an in-bench predictor of the breakpoint curve and its config.
// Depends on plc_pkg and the piecewise_linear_adjustment RTL only.
module piecewise_linear_adjustment_test;
  import plc_pkg::*;

  localparam int SLOTS       = MAX_POINTS_DEF;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CURVE_RUNS  = 41;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  plc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  plc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  piecewise_linear_adjustment #(.MAX_POINTS(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  plc_in_t            pending_beats[$];
  plc_out_t           expected_factors[$];
  logic signed [31:0] curve_x[SLOTS];
  logic signed [31:0] curve_y[SLOTS];
  logic               curve_on     = 1'b0;
  logic [3:0]         curve_points = '0;

  int mismatches      = 0;
  int loads_seen      = 0;
  int evals_seen      = 0;
  int defaults_seen   = 0;
  int results_checked = 0;
  int cycles          = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int run_left        = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic plc_out_t curve_factor(plc_in_t beat);
    plc_out_t        res;
    int              n;
    int              i;
    longint          v, lx, ly, rx, ry, dv, dx, dy, r;
    logic [63:0]     mdv, mdy, mdx, q;
    logic            neg;
    res.factor       = ONE_Q16;
    res.used_default = 1'b1;
    n = (curve_points > SLOTS) ? SLOTS : curve_points;
    if (!curve_on || !beat.sample_valid || n == 0) return res;
    res.used_default = 1'b0;
    v = beat.sample_value;
    if (v <= longint'(curve_x[0])) begin
      res.factor = curve_y[0];
    end else if (v >= longint'(curve_x[n-1])) begin
      res.factor = curve_y[n-1];
    end else begin
      i = 0;
      while (i + 1 < n - 1 && v >= longint'(curve_x[i+1])) i++;
      if (curve_x[i] == curve_x[i+1]) begin
        res.factor = curve_y[i];
      end else begin
        lx = curve_x[i];
        ly = curve_y[i];
        rx = curve_x[i+1];
        ry = curve_y[i+1];
        dv = v - lx;
        dx = rx - lx;
        dy = ry - ly;
        neg = ((dv < 0) != (dy < 0)) != (dx < 0);
        mdv = (dv < 0) ? -dv : dv;
        mdy = (dy < 0) ? -dy : dy;
        mdx = (dx < 0) ? -dx : dx;
        q = (mdv * mdy) / mdx;
        if (q > 64'h4_0000_0000) begin
          r = neg ? 0 : 64'h7FFF_FFFF;
        end else begin
          r = neg ? ly - longint'(q) : ly + longint'(q);
          if (r < 0) r = 0;
          if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        end
        res.factor = r[31:0];
      end
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 200)
      $display("ERROR result %0d: %s got %h want %h", results_checked, what, got, want);
    mismatches++;
  endtask

  // receiver: free and stalled runs of random length, each kind picked at random
  always @(posedge clk) begin
    if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b0;
          run_left  <= $urandom_range(20, 200);
        end
        1: begin
          out_stall <= 1'b1;
          run_left  <= $urandom_range(0, 2);
        end
        2: begin
          out_stall <= 1'b1;
          run_left  <= $urandom_range(10, 40);
        end
        default: begin
          out_stall <= 1'b0;
          run_left  <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict from accepted beats
  always @(posedge clk) begin : monitor
    plc_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_factors.size() == 0) begin
          report("unexpected result, factor", out_data.factor, '0);
        end else begin
          want = expected_factors.pop_front();
          if (out_data.factor !== want.factor)
            report("factor", out_data.factor, want.factor);
          if (out_data.used_default !== want.used_default)
            report("used_default", 32'(out_data.used_default), 32'(want.used_default));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_LOAD) begin
          curve_x[in_data.point_index] = in_data.point_x;
          curve_y[in_data.point_index] = in_data.point_y;
          loads_seen++;
        end else begin
          want = curve_factor(in_data);
          if (want.used_default) defaults_seen++;
          expected_factors.push_back(want);
          evals_seen++;
        end
      end
    end
  end

  task automatic push_load(int slot, logic signed [31:0] x, logic signed [31:0] y);
    plc_in_t beat;
    beat.kind         = KIND_LOAD;
    beat.point_index  = slot[2:0];
    beat.point_x      = x;
    beat.point_y      = y;
    beat.sample_value = $urandom;
    beat.sample_valid = 1'($urandom_range(0, 1));
    pending_beats.push_back(beat);
  endtask

  task automatic push_eval(logic signed [31:0] v, logic ok);
    plc_in_t beat;
    beat.kind         = KIND_EVAL;
    beat.point_index  = 3'($urandom_range(0, 7));
    beat.point_x      = $urandom;
    beat.point_y      = $urandom;
    beat.sample_value = v;
    beat.sample_valid = ok;
    pending_beats.push_back(beat);
  endtask

  // block is idle: nothing queued or in flight, loads given time to land
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_factors.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(logic en, logic [3:0] cnt);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= {3'b000, en};
    curve_on  = en;
    @(posedge clk);
    cfg_index    <= CFG_NUM_PTS;
    cfg_wdata    <= cnt;
    curve_points = cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_curve_run();
    int                 xq[$];
    logic signed [31:0] xs[SLOTS];
    logic signed [31:0] ys[SLOTS];
    int                 k, j, used, off, scale, ymode, pick, n_eval;
    logic [3:0]         cnt;
    logic signed [31:0] v;
    longint             lo, hi;
    longint unsigned    r64;
    scale = $urandom_range(0, 2);
    ymode = $urandom_range(0, 2);
    for (k = 0; k < SLOTS; k++) begin
      case (scale)
        0: xq.push_back($urandom);
        1: xq.push_back(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        default: xq.push_back(int'($urandom_range(0, 16)) * 32'sh8000 - 32'sh4_0000);
      endcase
    end
    // mostly ascending tables; the rest stay unsorted
    if ($urandom_range(0, 6) != 0) xq.sort();
    for (k = 0; k < SLOTS; k++) begin
      xs[k] = xq[k];
      if (k > 0 && $urandom_range(0, 9) == 0) xs[k] = xs[k-1];
      case (ymode)
        0: ys[k] = $urandom;
        1: ys[k] = $urandom_range(0, 32'h0004_0000);
        default: ys[k] = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0002_0000;
      endcase
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) cnt = 4'd0;
    else if (pick == 1) cnt = 4'd1;
    else if (pick <= 3) cnt = 4'($urandom_range(9, 15));
    else cnt = 4'($urandom_range(2, 8));
    set_config($urandom_range(0, 11) != 0, cnt);
    used = (cnt > SLOTS) ? SLOTS : cnt;
    off = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      j = (k + off) % SLOTS;
      push_load(j, xs[j], ys[j]);
    end
    n_eval = $urandom_range(22, 30);
    repeat (n_eval) begin
      if ($urandom_range(0, 24) == 0) begin
        j = $urandom_range(0, SLOTS - 1);
        xs[j] = $urandom;
        ys[j] = $urandom;
        push_load(j, xs[j], ys[j]);
      end
      j = (used > 1) ? $urandom_range(0, used - 2) : 0;
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = xs[j];
        2, 3: begin
          lo = xs[j];
          hi = xs[j+1];
          if (hi > lo) begin
            r64 = {$urandom, $urandom};
            v = 32'(lo + longint'(r64 % longint'(hi - lo)));
          end else begin
            v = xs[j];
          end
        end
        4: v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        default: v = xs[j] + int'($urandom_range(0, 6)) - 3;
      endcase
      push_eval(v, $urandom_range(0, 15) != 0);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int run;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset: disabled and empty, so every evaluation gives the default
    push_eval(32'sh0001_8000, 1'b1);
    push_eval(32'sh8000_0000, 1'b0);
    push_load(0, 32'sh8000_0000, 32'sh8000_0000);
    push_load(1, 32'sh8000_0002, 32'sh7FFF_FFFF);
    push_load(2, 32'sh0000_0000, 32'sh0000_0000);
    push_load(3, 32'sh0000_0000, 32'sh0001_0000);
    push_load(4, 32'sh0001_0000, 32'sh0003_0000);
    push_load(5, 32'sh0002_0000, 32'shFFFF_0000);
    push_load(6, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
    push_load(7, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
    wait_idle();

    set_config(1'b1, 4'd0);
    push_eval(32'sh0000_0000, 1'b1);
    wait_idle();

    // oversized count saturates to the full table
    set_config(1'b1, 4'd15);
    push_eval(32'sh8000_0000, 1'b1);
    push_eval(32'sh7FFF_FFFF, 1'b1);
    push_eval(32'sh8000_0001, 1'b1);
    push_eval(32'shFFFF_FFFF, 1'b1);
    push_eval(32'sh0000_0000, 1'b1);
    push_eval(32'sh0001_C000, 1'b1);
    push_eval(32'sh0001_F000, 1'b1);
    push_eval(32'sh4000_0000, 1'b1);
    push_eval(32'sh7FFF_FFFE, 1'b1);
    push_eval(32'sh0001_0000, 1'b0);
    wait_idle();

    set_config(1'b1, 4'd1);
    push_eval(32'sh8000_0000, 1'b1);
    push_eval(32'sh1234_5678, 1'b1);
    wait_idle();

    set_config(1'b1, 4'd2);
    push_eval(32'sh8000_0001, 1'b1);
    push_eval(32'sh0000_0000, 1'b1);
    wait_idle();

    set_config(1'b0, 4'd8);
    push_eval(32'sh0001_0000, 1'b1);
    wait_idle();

    for (run = 0; run < CURVE_RUNS; run++) random_curve_run();
    wait_idle();

    $display("Covered %0d loads and %0d evaluations (%0d at the default), %0d results checked",
             loads_seen, evals_seen, defaults_seen, results_checked);
    $display("Config swept enable on/off and counts 0..15 over %0d random curves", CURVE_RUNS);
    if (mismatches == 0 && expected_factors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
